// File: rtl/core/cac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cac_pkg
// Shared widths, types and step functions of the circle/box contact core.
// ----------------------------------------------------------------------------
package cac_pkg;

  // field widths
  localparam int CoordWidth = 24;
  localparam int RadW       = 16;
  localparam int DimW       = 16;
  localparam int NormW      = 16;
  localparam int PenW       = 17;
  localparam int ExtW       = CoordWidth + 2;
  localparam int SqW        = 2 * DimW;
  localparam int RootW      = 30;
  localparam int RadicW     = 2 * RootW;
  localparam int RemW       = 32;
  localparam int QuoW       = 16;
  localparam int DivdW      = DimW + 29;

  localparam logic [NormW-1:0] OneQ14   = NormW'(16384);
  localparam logic [RootW-1:0] DistHalf = RootW'(8192);

  // exit side of a center that lies inside the box
  typedef enum logic [1:0] {
    DirLeft,
    DirRight,
    DirTop,
    DirBottom
  } dir_e;

  typedef struct packed {
    logic signed [CoordWidth-1:0] center_x;
    logic signed [CoordWidth-1:0] center_y;
    logic [RadW-1:0]              circle_radius;
    logic signed [CoordWidth-1:0] box_left;
    logic signed [CoordWidth-1:0] box_top;
    logic [DimW-1:0]              box_width;
    logic [DimW-1:0]              box_height;
  } cac_req_t;

  typedef struct packed {
    logic              hit;
    logic signed [NormW-1:0] normal_x;
    logic signed [NormW-1:0] normal_y;
    logic [PenW-1:0]   penetration;
  } cac_rsp_t;

  // per-item context that rides along the pipeline
  typedef struct packed {
    logic            hit;
    logic            in_box;
    logic            neg_x;
    logic            neg_y;
    logic [DimW-1:0] mag_x;
    logic [DimW-1:0] mag_y;
    logic [RadW-1:0] radius;
    dir_e            dir;
    logic [PenW-1:0] in_pen;
  } cac_side_t;

  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } sqrt_step_t;

  typedef struct packed {
    logic [DivdW-1:0] rem;
    logic             bit_q;
  } div_step_t;

  // one digit of the square root recurrence
  function automatic sqrt_step_t sqrt_step(input logic [RemW-1:0] rem,
                                           input logic [RootW-1:0] root,
                                           input logic [1:0] pair);
    logic [RemW+1:0] part;
    logic [RemW+1:0] trial;
    logic            ge;
    sqrt_step_t      res;
    part  = {rem, pair};
    trial = {{(RemW-RootW){1'b0}}, root, 2'b01};
    ge    = (part >= trial);
    res.rem  = ge ? RemW'(part - trial) : RemW'(part);
    res.root = {root[RootW-2:0], ge};
    return res;
  endfunction

  // one quotient bit of the restoring divider
  function automatic div_step_t div_step(input logic [DivdW-1:0] rem,
                                         input logic [RootW-1:0] dvsr,
                                         input int unsigned sh);
    logic [DivdW:0] trial;
    logic           ge;
    div_step_t      res;
    trial = {{(DivdW+1-RootW){1'b0}}, dvsr} << sh;
    ge    = ({1'b0, rem} >= trial);
    res.rem   = ge ? DivdW'({1'b0, rem} - trial) : rem;
    res.bit_q = ge;
    return res;
  endfunction

endpackage

// File: rtl/core/cac_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cac_if
// Request and response channels of the circle/box contact core.
// ----------------------------------------------------------------------------
interface cac_req_if;
  import cac_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [CoordWidth-1:0] center_x;
  logic signed [CoordWidth-1:0] center_y;
  logic [RadW-1:0]              circle_radius;
  logic signed [CoordWidth-1:0] box_left;
  logic signed [CoordWidth-1:0] box_top;
  logic [DimW-1:0]              box_width;
  logic [DimW-1:0]              box_height;

  modport source (
    output valid, center_x, center_y, circle_radius, box_left, box_top,
           box_width, box_height,
    input  ready
  );
  modport sink (
    input  valid, center_x, center_y, circle_radius, box_left, box_top,
           box_width, box_height,
    output ready
  );
endinterface

interface cac_rsp_if;
  import cac_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic signed [NormW-1:0] normal_x;
  logic signed [NormW-1:0] normal_y;
  logic [PenW-1:0]         penetration;

  modport source (
    output valid, hit, normal_x, normal_y, penetration,
    input  ready
  );
  modport sink (
    input  valid, hit, normal_x, normal_y, penetration,
    output ready
  );
endinterface

// File: rtl/core/cac_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cac_front
// Clamp, offsets, squares and hit test over three register stages.
// ----------------------------------------------------------------------------
module cac_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  cac_pkg::cac_req_t       req_i,
  output logic                    valid_o,
  output cac_pkg::cac_side_t      side_o,
  output logic [cac_pkg::SqW-1:0] dsq_o
);
  import cac_pkg::*;

  // stage a: clamp and offsets
  logic signed [ExtW-1:0] cx, cy, lx, ty, rx, by, clx, cly, dx_d, dy_d;
  logic signed [ExtW-1:0] el_w, er_w, et_w, eb_w;
  logic                   a_v_q;
  logic signed [ExtW-1:0] a_dx_q, a_dy_q;
  logic [PenW-1:0]        a_el_q, a_er_q, a_et_q, a_eb_q;
  logic [RadW-1:0]        a_r_q;

  always_comb begin
    cx = {{2{req_i.center_x[CoordWidth-1]}}, req_i.center_x};
    cy = {{2{req_i.center_y[CoordWidth-1]}}, req_i.center_y};
    lx = {{2{req_i.box_left[CoordWidth-1]}}, req_i.box_left};
    ty = {{2{req_i.box_top[CoordWidth-1]}}, req_i.box_top};
    rx = lx + $signed({{(ExtW-DimW){1'b0}}, req_i.box_width});
    by = ty + $signed({{(ExtW-DimW){1'b0}}, req_i.box_height});
    clx = (cx > rx) ? rx : ((cx < lx) ? lx : cx);
    cly = (cy > by) ? by : ((cy < ty) ? ty : cy);
    dx_d = cx - clx;
    dy_d = cy - cly;
    el_w = cx - lx;
    er_w = rx - cx;
    et_w = cy - ty;
    eb_w = by - cy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (en_i) begin
      a_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_dx_q <= dx_d;
      a_dy_q <= dy_d;
      a_el_q <= el_w[PenW-1:0];
      a_er_q <= er_w[PenW-1:0];
      a_et_q <= et_w[PenW-1:0];
      a_eb_q <= eb_w[PenW-1:0];
      a_r_q  <= req_i.circle_radius;
    end
  end

  // stage b: magnitudes, squares, exit search
  logic [ExtW-1:0] mx, my;
  logic [PenW-1:0] best;
  dir_e            dir_d;
  logic            b_v_q, b_far_q;
  logic [SqW-1:0]  b_sqx_q, b_sqy_q, b_rsq_q;
  cac_side_t       b_side_q;

  always_comb begin
    mx = a_dx_q[ExtW-1] ? ExtW'(-a_dx_q) : ExtW'(a_dx_q);
    my = a_dy_q[ExtW-1] ? ExtW'(-a_dy_q) : ExtW'(a_dy_q);
    best  = a_el_q;
    dir_d = DirLeft;
    if (a_er_q < best) begin
      best  = a_er_q;
      dir_d = DirRight;
    end
    if (a_et_q < best) begin
      best  = a_et_q;
      dir_d = DirTop;
    end
    if (a_eb_q < best) begin
      best  = a_eb_q;
      dir_d = DirBottom;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (en_i) begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_far_q         <= (|mx[ExtW-1:DimW]) || (|my[ExtW-1:DimW]);
      b_sqx_q         <= mx[DimW-1:0] * mx[DimW-1:0];
      b_sqy_q         <= my[DimW-1:0] * my[DimW-1:0];
      b_rsq_q         <= a_r_q * a_r_q;
      b_side_q.hit    <= 1'b0;
      b_side_q.in_box <= 1'b0;
      b_side_q.neg_x  <= a_dx_q[ExtW-1];
      b_side_q.neg_y  <= a_dy_q[ExtW-1];
      b_side_q.mag_x  <= mx[DimW-1:0];
      b_side_q.mag_y  <= my[DimW-1:0];
      b_side_q.radius <= a_r_q;
      b_side_q.dir    <= dir_d;
      b_side_q.in_pen <= PenW'({1'b0, a_r_q} + best);
    end
  end

  // stage c: squared distance and hit decision
  logic [SqW:0] dsq;
  logic         c_v_q;
  cac_side_t    c_side_d;
  cac_side_t    c_side_q;
  logic [SqW-1:0] c_dsq_q;

  assign dsq = {1'b0, b_sqx_q} + {1'b0, b_sqy_q};

  always_comb begin
    c_side_d        = b_side_q;
    c_side_d.hit    = !b_far_q && (dsq < {1'b0, b_rsq_q});
    c_side_d.in_box = (dsq == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else if (en_i) begin
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_side_q <= c_side_d;
      c_dsq_q  <= dsq[SqW-1:0];
    end
  end

  assign valid_o = c_v_q;
  assign side_o  = c_side_q;
  assign dsq_o   = c_dsq_q;

endmodule

// File: rtl/core/cac_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cac_sqrt
// Pipelined digit-by-digit square root, one root bit per stage.
// ----------------------------------------------------------------------------
module cac_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  cac_pkg::cac_side_t        side_i,
  input  logic [cac_pkg::SqW-1:0]   dsq_i,
  output logic                      valid_o,
  output cac_pkg::cac_side_t        side_o,
  output logic [cac_pkg::RootW-1:0] root_o
);
  import cac_pkg::*;

  logic             v_q    [RootW];
  cac_side_t        side_q [RootW];
  logic [RadicW-1:0] rad_q [RootW];
  logic [RemW-1:0]  rem_q  [RootW];
  logic [RootW-1:0] root_q [RootW];

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    logic              v_in;
    cac_side_t         side_in;
    logic [RadicW-1:0] rad_in;
    logic [RemW-1:0]   rem_in;
    logic [RootW-1:0]  root_in;
    sqrt_step_t        st;

    // stage input: front result or previous stage
    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign side_in = side_i;
      assign rad_in  = {dsq_i, {(RadicW-SqW){1'b0}}};
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign side_in = side_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    assign st = sqrt_step(rem_in, root_in, rad_in[RadicW-1:RadicW-2]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= side_in;
        rad_q[k]  <= {rad_in[RadicW-3:0], 2'b00};
        rem_q[k]  <= st.rem;
        root_q[k] <= st.root;
      end
    end
  end

  assign valid_o = v_q[RootW-1];
  assign side_o  = side_q[RootW-1];
  assign root_o  = root_q[RootW-1];

endmodule

// File: rtl/core/cac_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cac_div
// Two pipelined restoring dividers, offset over distance, one bit per stage.
// ----------------------------------------------------------------------------
module cac_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  cac_pkg::cac_side_t        side_i,
  input  logic [cac_pkg::RootW-1:0] root_i,
  output logic                      valid_o,
  output cac_pkg::cac_side_t        side_o,
  output logic [cac_pkg::RootW-1:0] root_o,
  output logic [cac_pkg::QuoW-1:0]  quo_x_o,
  output logic [cac_pkg::QuoW-1:0]  quo_y_o
);
  import cac_pkg::*;

  logic             v_q    [QuoW];
  cac_side_t        side_q [QuoW];
  logic [RootW-1:0] root_q [QuoW];
  logic [DivdW-1:0] remx_q [QuoW];
  logic [DivdW-1:0] remy_q [QuoW];
  logic [QuoW-1:0]  qx_q   [QuoW];
  logic [QuoW-1:0]  qy_q   [QuoW];

  for (genvar k = 0; k < QuoW; k++) begin : g_stage
    logic             v_in;
    cac_side_t        side_in;
    logic [RootW-1:0] root_in;
    logic [DivdW-1:0] remx_in, remy_in;
    logic [QuoW-1:0]  qx_in, qy_in;
    div_step_t        sx, sy;

    // stage input: root result or previous stage
    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign side_in = side_i;
      assign root_in = root_i;
      assign remx_in = {side_i.mag_x, {(DivdW-DimW){1'b0}}};
      assign remy_in = {side_i.mag_y, {(DivdW-DimW){1'b0}}};
      assign qx_in   = '0;
      assign qy_in   = '0;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign side_in = side_q[k-1];
      assign root_in = root_q[k-1];
      assign remx_in = remx_q[k-1];
      assign remy_in = remy_q[k-1];
      assign qx_in   = qx_q[k-1];
      assign qy_in   = qy_q[k-1];
    end

    assign sx = div_step(remx_in, root_in, QuoW - 1 - k);
    assign sy = div_step(remy_in, root_in, QuoW - 1 - k);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= side_in;
        root_q[k] <= root_in;
        remx_q[k] <= sx.rem;
        remy_q[k] <= sy.rem;
        qx_q[k]   <= {qx_in[QuoW-2:0], sx.bit_q};
        qy_q[k]   <= {qy_in[QuoW-2:0], sy.bit_q};
      end
    end
  end

  assign valid_o = v_q[QuoW-1];
  assign side_o  = side_q[QuoW-1];
  assign root_o  = root_q[QuoW-1];
  assign quo_x_o = qx_q[QuoW-1];
  assign quo_y_o = qy_q[QuoW-1];

endmodule

// File: rtl/core/cac_finish.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cac_finish
// Rounds and saturates the normal, forms the depth, holds the output register.
// ----------------------------------------------------------------------------
module cac_finish (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  cac_pkg::cac_side_t        side_i,
  input  logic [cac_pkg::RootW-1:0] root_i,
  input  logic [cac_pkg::QuoW-1:0]  quo_x_i,
  input  logic [cac_pkg::QuoW-1:0]  quo_y_i,
  output logic                      valid_o,
  output cac_pkg::cac_rsp_t         rsp_o
);
  import cac_pkg::*;

  // rounded, saturated, signed normal component
  function automatic logic [NormW-1:0] norm_comp(input logic [QuoW-1:0] q,
                                                 input logic neg);
    logic [QuoW:0]    sum;
    logic [NormW-1:0] mag;
    sum = {1'b0, q} + (QuoW+1)'(1);
    mag = (sum[QuoW:1] > OneQ14) ? OneQ14 : sum[QuoW:1];
    return neg ? NormW'(-mag) : mag;
  endfunction

  logic [RootW:0]  dist_sum;
  logic [PenW-1:0] dist8;
  logic [PenW-1:0] rad_ext;
  cac_rsp_t        rsp_d;
  logic            v_q;
  cac_rsp_t        rsp_q;

  always_comb begin
    dist_sum = {1'b0, root_i} + {1'b0, DistHalf};
    dist8    = dist_sum[RootW:RootW-PenW+1];
    rad_ext  = {1'b0, side_i.radius};
    rsp_d    = '0;
    if (side_i.hit) begin
      rsp_d.hit = 1'b1;
      if (side_i.in_box) begin
        rsp_d.penetration = side_i.in_pen;
        case (side_i.dir)
          DirLeft:   rsp_d.normal_x = NormW'(-OneQ14);
          DirRight:  rsp_d.normal_x = OneQ14;
          DirTop:    rsp_d.normal_y = NormW'(-OneQ14);
          DirBottom: rsp_d.normal_y = OneQ14;
          default:   rsp_d.normal_x = '0;
        endcase
      end else begin
        rsp_d.normal_x    = norm_comp(quo_x_i, side_i.neg_x);
        rsp_d.normal_y    = norm_comp(quo_y_i, side_i.neg_y);
        rsp_d.penetration = (rad_ext > dist8) ? PenW'(rad_ext - dist8) : '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rsp_q <= rsp_d;
    end
  end

  assign valid_o = v_q;
  assign rsp_o   = rsp_q;

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q && !rsp_q.hit) |->
      (rsp_q.normal_x == '0 && rsp_q.normal_y == '0 && rsp_q.penetration == '0))
    else $error("miss carries nonzero fields");

  a_norm_x_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q |-> ($signed(rsp_q.normal_x) <= $signed(OneQ14) &&
             $signed(rsp_q.normal_x) >= -$signed(OneQ14)))
    else $error("normal x out of range");

  a_norm_y_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q |-> ($signed(rsp_q.normal_y) <= $signed(OneQ14) &&
             $signed(rsp_q.normal_y) >= -$signed(OneQ14)))
    else $error("normal y out of range");

  a_hit_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q && rsp_q.hit) |-> (rsp_q.normal_x != '0 || rsp_q.normal_y != '0))
    else $error("hit with zero normal");

endmodule

// File: rtl/core/circle_aabb_contact_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_aabb_contact_core
// Circle against axis-aligned box contact test: hit, unit normal, depth.
// ----------------------------------------------------------------------------
//  port   | dir | carries
//  -------+-----+---------------------------------------------------------
//  req_i  | in  | circle center, radius, box corner, width and height
//  rsp_o  | out | hit flag, Q1.14 normal x/y, depth with 0 fraction bits
//
//  one request per cycle unless the output stalls; three front stages,
//  thirty square root stages, sixteen divider stages, one output register
//  the pipeline advances as one whenever the output register is empty or
//  taken; a stalled output freezes every stage, nothing is dropped
//  reset clears the stage valid bits only
// ----------------------------------------------------------------------------
module circle_aabb_contact_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  cac_req_if.sink   req_i,
  cac_rsp_if.source rsp_o
);
  import cac_pkg::*;

  logic             en;
  cac_req_t         req;
  logic             f_v, s_v, d_v, o_v;
  cac_side_t        f_side, s_side, d_side;
  logic [SqW-1:0]   f_dsq;
  logic [RootW-1:0] s_root, d_root;
  logic [QuoW-1:0]  d_qx, d_qy;
  cac_rsp_t         rsp;

  // global advance
  assign en        = !o_v || rsp_o.ready;
  assign req_i.ready = en;

  // request packing
  always_comb begin
    req.center_x      = req_i.center_x;
    req.center_y      = req_i.center_y;
    req.circle_radius = req_i.circle_radius;
    req.box_left      = req_i.box_left;
    req.box_top       = req_i.box_top;
    req.box_width     = req_i.box_width;
    req.box_height    = req_i.box_height;
  end

  cac_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (req_i.valid),
    .req_i   (req),
    .valid_o (f_v),
    .side_o  (f_side),
    .dsq_o   (f_dsq)
  );

  cac_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_v),
    .side_i  (f_side),
    .dsq_i   (f_dsq),
    .valid_o (s_v),
    .side_o  (s_side),
    .root_o  (s_root)
  );

  cac_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_v),
    .side_i  (s_side),
    .root_i  (s_root),
    .valid_o (d_v),
    .side_o  (d_side),
    .root_o  (d_root),
    .quo_x_o (d_qx),
    .quo_y_o (d_qy)
  );

  cac_finish u_finish (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d_v),
    .side_i  (d_side),
    .root_i  (d_root),
    .quo_x_i (d_qx),
    .quo_y_i (d_qy),
    .valid_o (o_v),
    .rsp_o   (rsp)
  );

  // response unpacking
  assign rsp_o.valid       = o_v;
  assign rsp_o.hit         = rsp.hit;
  assign rsp_o.normal_x    = rsp.normal_x;
  assign rsp_o.normal_y    = rsp.normal_y;
  assign rsp_o.penetration = rsp.penetration;

endmodule
